FILE: design/frmp_pkg.sv
package frmp_pkg;

    localparam int MAX_BODY_DEFAULT   = 4096;
    localparam int TOKEN_FRAC_DEFAULT = 16;
    localparam int HEADER_BYTES       = 4;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [12:0] MAX_BODY_LEN_RST   = 13'd4096;
    localparam logic [7:0]  BUCKET_CAP_RST     = 8'd80;
    localparam logic [23:0] REFILL_RST         = 24'd2621;
    localparam logic [31:0] HEADER_TIMEOUT_RST = 32'd120000;
    localparam logic [31:0] BODY_TIMEOUT_RST   = 32'd15000;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic KIND_BYTE  = 1'b0;
    localparam logic KIND_CLOSE = 1'b1;

    typedef enum logic [2:0] {
        ST_OK             = 3'd0,
        ST_BAD_ID         = 3'd1,
        ST_BAD_LEN        = 3'd2,
        ST_RATE           = 3'd3,
        ST_HEADER_TIMEOUT = 3'd4,
        ST_BODY_TIMEOUT   = 3'd5
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_BODY_LEN   = 3'd0,
        CFG_BUCKET_CAP     = 3'd1,
        CFG_REFILL         = 3'd2,
        CFG_HEADER_TIMEOUT = 3'd3,
        CFG_BODY_TIMEOUT   = 3'd4
    } t_cfg_idx;

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_BODY   = 3'b010,
        PH_CLOSED = 3'b100
    } t_phase;

    typedef struct packed {
        logic [12:0] max_body_len;
        logic [7:0]  bucket_capacity;
        logic [23:0] refill_per_tick;
        logic [31:0] header_timeout_ticks;
        logic [31:0] body_timeout_ticks;
    } t_cfg;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
    } t_item;

    typedef struct packed {
        logic        kind;
        logic [7:0]  body_byte;
        logic [14:0] message_id;
        logic [12:0] message_len;
        logic        last;
        logic [2:0]  status;
    } t_result;

endpackage

FILE: design/frmp_in_if.sv
interface frmp_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] data_byte;

    modport source(output valid, output op, output data_byte, input ready);
    modport sink(input valid, input op, input data_byte, output ready);
endinterface

FILE: design/frmp_out_if.sv
interface frmp_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  body_byte;
    logic [14:0] message_id;
    logic [12:0] message_len;
    logic        last;
    logic [2:0]  status;

    modport source(
        output valid, output kind, output body_byte, output message_id,
        output message_len, output last, output status, input ready
    );
    modport sink(
        input valid, input kind, input body_byte, input message_id,
        input message_len, input last, input status, output ready
    );
endinterface

FILE: design/frmp_cfg_regs.sv
module frmp_cfg_regs
    import frmp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_BODY_LEN:   n_cfg.max_body_len = i_cfg_data[12:0];
                CFG_BUCKET_CAP:     n_cfg.bucket_capacity = i_cfg_data[7:0];
                CFG_REFILL:         n_cfg.refill_per_tick = i_cfg_data[23:0];
                CFG_HEADER_TIMEOUT: n_cfg.header_timeout_ticks = i_cfg_data;
                CFG_BODY_TIMEOUT:   n_cfg.body_timeout_ticks = i_cfg_data;
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_body_len         <= MAX_BODY_LEN_RST;
            r_cfg.bucket_capacity      <= BUCKET_CAP_RST;
            r_cfg.refill_per_tick      <= REFILL_RST;
            r_cfg.header_timeout_ticks <= HEADER_TIMEOUT_RST;
            r_cfg.body_timeout_ticks   <= BODY_TIMEOUT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: design/frmp_in_stage.sv
module frmp_in_stage
    import frmp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    frmp_in_if.sink i_in,
    input  logic    i_take,
    output logic    o_valid,
    output t_item   o_item
);

    logic  r_valid;
    t_item r_item;
    logic  accept;

    assign i_in.ready = !r_valid || i_take;
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item.op        <= i_in.op;
            r_item.data_byte <= i_in.data_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: design/frmp_core.sv
module frmp_core
    import frmp_pkg::*;
#(
    parameter int MAX_BODY        = MAX_BODY_DEFAULT,
    parameter int TOKEN_FRAC_BITS = TOKEN_FRAC_DEFAULT
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_fire,
    input  t_item   i_item,
    output logic    o_res_valid,
    output t_result o_res
);

    localparam int BW = 8 + TOKEN_FRAC_BITS;
    localparam int SW = ((BW > 24) ? BW : 24) + 1;
    localparam int LW = $clog2(MAX_BODY + 1);
    localparam logic [SW-1:0] ONE_TOKEN = SW'(1) << TOKEN_FRAC_BITS;
    localparam logic [15:0] MAX_BODY_16 = 16'(MAX_BODY);
    localparam logic [1:0]  HDR_LAST = 2'(HEADER_BYTES - 1);

    t_phase      r_phase, n_phase;
    logic [1:0]  r_hdr_count, n_hdr_count;
    logic [23:0] r_hdr_shift, n_hdr_shift;
    logic [14:0] r_frame_id, n_frame_id;
    logic [LW-1:0] r_frame_len, n_frame_len;
    logic [LW-1:0] r_body_count, n_body_count;
    logic [BW-1:0] r_budget, n_budget;
    logic [31:0] r_deadline, n_deadline;

    logic [SW-1:0] cap_ext;
    logic [SW-1:0] budget_ext;
    logic [SW-1:0] refill_sum;
    logic [SW-1:0] tick_budget;
    logic [SW-1:0] clamp_budget;
    logic [31:0]   deadline_inc;
    logic [31:0]   limit;
    logic [15:0]   hdr_id;
    logic [15:0]   hdr_len;
    logic [15:0]   max_len;
    logic [LW-1:0] count_inc;

    assign cap_ext      = SW'({i_cfg.bucket_capacity, {TOKEN_FRAC_BITS{1'b0}}});
    assign budget_ext   = SW'(r_budget);
    assign refill_sum   = budget_ext + SW'(i_cfg.refill_per_tick);
    assign tick_budget  = (refill_sum > cap_ext) ? cap_ext : refill_sum;
    assign clamp_budget = (budget_ext > cap_ext) ? cap_ext : budget_ext;
    assign deadline_inc = (r_deadline == '1) ? r_deadline : r_deadline + 32'd1;
    assign limit        = (r_phase == PH_HEADER) ? i_cfg.header_timeout_ticks
                                                 : i_cfg.body_timeout_ticks;
    assign hdr_id       = r_hdr_shift[23:8];
    assign hdr_len      = {r_hdr_shift[7:0], i_item.data_byte};
    assign max_len      = (16'(i_cfg.max_body_len) > MAX_BODY_16) ? MAX_BODY_16
                                                                : 16'(i_cfg.max_body_len);
    assign count_inc    = r_body_count + LW'(1);

    always_comb begin
        n_phase      = r_phase;
        n_hdr_count  = r_hdr_count;
        n_hdr_shift  = r_hdr_shift;
        n_frame_id   = r_frame_id;
        n_frame_len  = r_frame_len;
        n_body_count = r_body_count;
        n_budget     = r_budget;
        n_deadline   = r_deadline;
        o_res_valid  = 1'b0;
        o_res        = '0;

        if (r_phase != PH_CLOSED && i_item.op == OP_TICK) begin
            n_budget   = BW'(tick_budget);
            n_deadline = deadline_inc;
            if (deadline_inc >= limit) begin
                n_phase      = PH_CLOSED;
                o_res_valid  = 1'b1;
                o_res.kind   = KIND_CLOSE;
                o_res.status = (r_phase == PH_HEADER) ? ST_HEADER_TIMEOUT
                                                      : ST_BODY_TIMEOUT;
            end
        end else begin
            case (r_phase)
                PH_HEADER: begin
                    if (r_hdr_count != HDR_LAST) begin
                        n_hdr_shift = {r_hdr_shift[15:0], i_item.data_byte};
                        n_hdr_count = r_hdr_count + 2'd1;
                    end else begin
                        n_hdr_count = '0;
                        n_hdr_shift = '0;
                        if (hdr_id == 16'd0 || hdr_id[15]) begin
                            n_phase      = PH_CLOSED;
                            o_res_valid  = 1'b1;
                            o_res.kind   = KIND_CLOSE;
                            o_res.status = ST_BAD_ID;
                        end else if (hdr_len == 16'd0 || hdr_len > max_len) begin
                            n_phase      = PH_CLOSED;
                            o_res_valid  = 1'b1;
                            o_res.kind   = KIND_CLOSE;
                            o_res.status = ST_BAD_LEN;
                        end else begin
                            n_frame_id   = hdr_id[14:0];
                            n_frame_len  = LW'(hdr_len);
                            n_body_count = '0;
                            n_phase      = PH_BODY;
                            n_deadline   = '0;
                        end
                    end
                end
                PH_BODY: begin
                    n_body_count      = count_inc;
                    o_res_valid       = 1'b1;
                    o_res.kind        = KIND_BYTE;
                    o_res.body_byte   = i_item.data_byte;
                    o_res.message_id  = r_frame_id;
                    o_res.message_len = 13'(r_frame_len);
                    o_res.status      = ST_OK;
                    if (count_inc == r_frame_len) begin
                        if (clamp_budget < ONE_TOKEN) begin
                            n_budget = BW'(clamp_budget);
                            n_phase  = PH_CLOSED;
                            o_res    = '0;
                            o_res.kind   = KIND_CLOSE;
                            o_res.status = ST_RATE;
                        end else begin
                            n_budget     = BW'(clamp_budget - ONE_TOKEN);
                            o_res.last   = 1'b1;
                            n_body_count = '0;
                            n_phase      = PH_HEADER;
                            n_hdr_count  = '0;
                            n_hdr_shift  = '0;
                            n_deadline   = '0;
                        end
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HEADER;
            r_hdr_count  <= '0;
            r_hdr_shift  <= '0;
            r_frame_id   <= '0;
            r_frame_len  <= '0;
            r_body_count <= '0;
            r_budget     <= BW'({BUCKET_CAP_RST, {TOKEN_FRAC_BITS{1'b0}}});
            r_deadline   <= '0;
        end else if (i_fire) begin
            r_phase      <= n_phase;
            r_hdr_count  <= n_hdr_count;
            r_hdr_shift  <= n_hdr_shift;
            r_frame_id   <= n_frame_id;
            r_frame_len  <= n_frame_len;
            r_body_count <= n_body_count;
            r_budget     <= n_budget;
            r_deadline   <= n_deadline;
        end
    end

endmodule

FILE: design/frmp_out_stage.sv
module frmp_out_stage
    import frmp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_result    i_res,
    output logic       o_space,
    frmp_out_if.source o_out
);

    logic    r_valid;
    t_result r_res;

    assign o_space = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.kind        = r_res.kind;
    assign o_out.body_byte   = r_res.body_byte;
    assign o_out.message_id  = r_res.message_id;
    assign o_out.message_len = r_res.message_len;
    assign o_out.last        = r_res.last;
    assign o_out.status      = r_res.status;

endmodule

FILE: design/framed_message_receiver_policer_unit.sv
// A result item is registered in the output stage when its input item is taken.
// Throughput: one input item per cycle, byte or tick, as long as results are taken.
// The header check, token charge and deadline compare are all done in one pass
// between the input register and the result register.
// Reset is synchronous and active low; it restores the register defaults,
// opens a fresh session in the header phase and fills the token bucket.
module framed_message_receiver_policer_unit
    import frmp_pkg::*;
#(
    parameter int MAX_BODY        = MAX_BODY_DEFAULT,
    parameter int TOKEN_FRAC_BITS = TOKEN_FRAC_DEFAULT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    frmp_in_if.sink               i_in,
    frmp_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg    cfg;
    logic    item_valid;
    t_item   item;
    logic    out_space;
    logic    take;
    logic    res_valid;
    t_result res;

    assign take = item_valid && out_space;

    frmp_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    frmp_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_take  (take),
        .o_valid (item_valid),
        .o_item  (item)
    );

    frmp_core #(
        .MAX_BODY        (MAX_BODY),
        .TOKEN_FRAC_BITS (TOKEN_FRAC_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_fire      (take),
        .i_item      (item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    frmp_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (take && res_valid),
        .i_res   (res),
        .o_space (out_space),
        .o_out   (o_out)
    );

endmodule
